FILE: design/alhd_pkg.sv
// Shared types and constants for the averaged level hysteresis detector.
// No dependencies; imported by every module of the block.
package alhd_pkg;

  localparam int SAMPLE_W       = 12;
  localparam int WINDOW_LEN_DEF = 16;
  localparam int CFG_IDX_W      = 1;

  typedef logic [SAMPLE_W-1:0] sample_t;

  localparam sample_t TURN_ON_RST  = 12'd2500;
  localparam sample_t TURN_OFF_RST = 12'd1500;

  // Register map of the write port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TURN_ON  = 1'b0,
    CFG_TURN_OFF = 1'b1
  } cfg_idx_e;

  // Threshold pair seen by the decision stage
  typedef struct packed {
    sample_t turn_on;
    sample_t turn_off;
  } thr_t;

  // Request leaving the window stage: newest sample and the one it replaces
  typedef struct packed {
    sample_t sample;
    sample_t oldest;
  } win_item_t;

endpackage

FILE: design/alhd_window.sv
// Sample window: circular buffer memory, write pointer and input register.
// Depends on alhd_pkg.
module alhd_window import alhd_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sample_t   sample_i,
  output logic      item_valid_o,
  input  logic      item_ready_i,
  output win_item_t item_o
);

  localparam int PTR_W = $clog2(WINDOW_LEN);
  localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(WINDOW_LEN - 1);

  sample_t          mem_q [WINDOW_LEN];
  sample_t          rd_q;
  sample_t          sample_q;
  logic             old_valid_q;
  logic [PTR_W-1:0] pos_q, pos_d;
  logic             full_q, full_d;
  logic             valid_q, valid_d;
  logic             accept;

  assign in_ready_o = !valid_q || item_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Pointer, first-pass flag and stage valid
  always_comb begin
    pos_d   = pos_q;
    full_d  = full_q;
    valid_d = valid_q && !item_ready_i;
    if (accept) begin
      valid_d = 1'b1;
      if (pos_q == LAST_POS) begin
        pos_d  = '0;
        full_d = 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      full_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      full_q  <= full_d;
      valid_q <= valid_d;
    end
  end

  // Memory: read the oldest entry and overwrite it in the same cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q          <= mem_q[pos_q];
      mem_q[pos_q]  <= sample_i;
      sample_q      <= sample_i;
      old_valid_q   <= full_q;
    end
  end

  // Entries not yet written on the first pass count as zero
  assign item_valid_o   = valid_q;
  assign item_o.sample  = sample_q;
  assign item_o.oldest  = old_valid_q ? rd_q : '0;

  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && pos_q == LAST_POS |=> pos_q == '0 && full_q)
    else $error("window pointer did not wrap");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !item_ready_i |=> valid_q && $stable(sample_q))
    else $error("stalled window item changed");

endmodule

FILE: design/alhd_sum.sv
// Running sum of the window: adds the newest sample, drops the oldest.
// Depends on alhd_pkg.
module alhd_sum import alhd_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int SUM_W      = $clog2(WINDOW_LEN * ((1 << SAMPLE_W) - 1) + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  win_item_t        item_i,
  output logic             sum_valid_o,
  input  logic             sum_ready_i,
  output logic [SUM_W-1:0] sum_o
);

  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW_LEN * ((1 << SAMPLE_W) - 1));

  logic [SUM_W-1:0] sum_q, sum_d;
  logic             valid_q, valid_d;
  logic             load;

  assign item_ready_o = !valid_q || sum_ready_i;
  assign load         = item_valid_i && item_ready_o;

  // Sum never goes below the entry being removed, so no underflow
  always_comb begin
    sum_d   = sum_q;
    valid_d = valid_q && !sum_ready_i;
    if (load) begin
      sum_d   = sum_q - SUM_W'(item_i.oldest) + SUM_W'(item_i.sample);
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      valid_q <= valid_d;
    end
  end

  assign sum_valid_o = valid_q;
  assign sum_o       = sum_q;

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= SUM_MAX)
    else $error("window sum out of range");

endmodule

FILE: design/alhd_decide.sv
// Mean by reciprocal multiply, hysteresis decision and result register.
// Depends on alhd_pkg.
module alhd_decide import alhd_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int SUM_W      = $clog2(WINDOW_LEN * ((1 << SAMPLE_W) - 1) + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  thr_t             thr_i,
  input  logic             sum_valid_i,
  output logic             sum_ready_o,
  input  logic [SUM_W-1:0] sum_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sample_t          mean_level_o,
  output logic             is_on_o
);

  // Exact floor division for every sum below 2**SUM_W
  localparam int LOG_N   = $clog2(WINDOW_LEN);
  localparam int SHIFT   = SUM_W + LOG_N;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);

  logic [PROD_W-1:0] prod_c;
  sample_t           mean_c;
  sample_t           mean_q;
  logic              on_q, on_d;
  logic              valid_q, valid_d;
  logic              load;

  assign sum_ready_o = !valid_q || out_ready_i;
  assign load        = sum_valid_i && sum_ready_o;

  // Mean
  assign prod_c = PROD_W'(sum_i) * PROD_W'(RECIP);
  assign mean_c = SAMPLE_W'(prod_c >> SHIFT);

  // Hysteresis: the on test takes priority when thresholds cross
  always_comb begin
    on_d    = on_q;
    valid_d = valid_q && !out_ready_i;
    if (load) begin
      valid_d = 1'b1;
      if (mean_c > thr_i.turn_on) begin
        on_d = 1'b1;
      end else if (mean_c < thr_i.turn_off) begin
        on_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      on_q    <= on_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mean_q <= mean_c;
    end
  end

  assign out_valid_o  = valid_q;
  assign mean_level_o = mean_q;
  assign is_on_o      = on_q;

  a_turn_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && mean_c > thr_i.turn_on |=> is_on_o)
    else $error("mean above turn-on threshold did not set state");

  a_turn_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && mean_c < thr_i.turn_off && mean_c <= thr_i.turn_on |=> !is_on_o)
    else $error("mean below turn-off threshold did not clear state");

  a_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load |=> $stable(is_on_o))
    else $error("state changed without a new mean");

endmodule

FILE: design/averaged_level_hysteresis_detector_unit.sv
// Averaged level hysteresis detector: top level with threshold registers.
// Path: the accept edge loads the window read; the running sum register, then
// the reciprocal multiply and decision into the result register, follow.
// Throughput: one sample per cycle while out_ready_i is high; the running sum
// needs only the newest and the oldest sample, and every stage passes a
// request on each cycle unless the stage after it stalls.
// Reset: window reads as zero, sum zero, state off, thresholds 2500 / 1500.
module averaged_level_hysteresis_detector_unit import alhd_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SAMPLE_W-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SAMPLE_W-1:0]  sample_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SAMPLE_W-1:0]  mean_level_o,
  output logic                 is_on_o
);

  localparam int SUM_W = $clog2(WINDOW_LEN * ((1 << SAMPLE_W) - 1) + 1);

  thr_t             thr_q;
  win_item_t        item;
  logic             item_valid, item_ready;
  logic [SUM_W-1:0] sum;
  logic             sum_valid, sum_ready;

  // Threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.turn_on  <= TURN_ON_RST;
      thr_q.turn_off <= TURN_OFF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TURN_ON:  thr_q.turn_on  <= cfg_data_i;
        CFG_TURN_OFF: thr_q.turn_off <= cfg_data_i;
        default: ;
      endcase
    end
  end

  alhd_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  alhd_sum #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_sum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .sum_valid_o  (sum_valid),
    .sum_ready_i  (sum_ready),
    .sum_o        (sum)
  );

  alhd_decide #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_decide (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .thr_i        (thr_q),
    .sum_valid_i  (sum_valid),
    .sum_ready_o  (sum_ready),
    .sum_i        (sum),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mean_level_o (mean_level_o),
    .is_on_o      (is_on_o)
  );

endmodule

FILE: bench/alhd_result_checker.sv
// Result checker for the averaged level hysteresis detector.
// Watches the write port and both request channels, predicts every result.
// Depends on alhd_pkg; instantiated next to the block by the testbench top.
module alhd_result_checker import alhd_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SAMPLE_W-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [SAMPLE_W-1:0]  sample_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [SAMPLE_W-1:0]  mean_level_i,
  input  logic                 is_on_i,
  output int                   mismatch_cnt_o,
  output int                   pending_o
);

  // Enough bits for WINDOW_LEN full-scale samples
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LEN);

  typedef struct packed {
    sample_t mean;
    logic    on;
  } level_result_t;

  // Shadow of the block state
  sample_t          window_q [WINDOW_LEN];
  logic [SUM_W-1:0] sum_q;
  int unsigned      wr_pos_q;
  logic             on_q;
  thr_t             thr_q;

  level_result_t    expected_levels [$];
  int               mismatches;
  int               results_seen;

  // Slide the window by one sample and return mean and decision after it
  function automatic level_result_t next_level(input sample_t s);
    level_result_t res;
    sum_q              = sum_q - SUM_W'(window_q[wr_pos_q]) + SUM_W'(s);
    window_q[wr_pos_q] = s;
    wr_pos_q           = (wr_pos_q + 1 == WINDOW_LEN) ? 0 : wr_pos_q + 1;
    res.mean           = sample_t'(sum_q / WINDOW_LEN);
    // On test first: with crossed thresholds it wins
    if (res.mean > thr_q.turn_on) begin
      on_q = 1'b1;
    end else if (res.mean < thr_q.turn_off) begin
      on_q = 1'b0;
    end
    res.on = on_q;
    return res;
  endfunction

  function automatic void report_mismatch(input string what, input int exp_v, input int act_v);
    if (mismatches < 10) begin
      $display("[%0t] result %0d: %s mismatch, expected %0d, got %0d",
               $time, results_seen, what, exp_v, act_v);
    end
    mismatches++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    level_result_t exp_r;
    if (!rst_ni) begin
      foreach (window_q[i]) window_q[i] = '0;
      sum_q          = '0;
      wr_pos_q       = 0;
      on_q           = 1'b0;
      thr_q.turn_on  = TURN_ON_RST;
      thr_q.turn_off = TURN_OFF_RST;
      expected_levels.delete();
      mismatches     = 0;
      results_seen   = 0;
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
    end else begin
      // Threshold writes
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TURN_ON:  thr_q.turn_on  = cfg_data_i;
          CFG_TURN_OFF: thr_q.turn_off = cfg_data_i;
          default: ;
        endcase
      end
      // Accepted sample request: one result expected
      if (in_valid_i && in_ready_i) begin
        expected_levels.push_back(next_level(sample_i));
      end
      // Accepted result: compare with the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (expected_levels.size() == 0) begin
          report_mismatch("unexpected result, mean", -1, int'(mean_level_i));
        end else begin
          exp_r = expected_levels.pop_front();
          if (mean_level_i !== exp_r.mean) begin
            report_mismatch("mean_level", int'(exp_r.mean), int'(mean_level_i));
          end
          if (is_on_i !== exp_r.on) begin
            report_mismatch("is_on", int'(exp_r.on), int'(is_on_i));
          end
        end
        results_seen++;
      end
      mismatch_cnt_o <= mismatches;
      pending_o      <= expected_levels.size();
    end
  end

endmodule

FILE: bench/tb_averaged_level_hysteresis_detector_unit.sv
// Testbench top for averaged_level_hysteresis_detector_unit: clock, reset,
// threshold writes and sample stimulus. Depends on alhd_pkg, the block and
// alhd_result_checker, which does all prediction and comparison.
module tb_averaged_level_hysteresis_detector_unit import alhd_pkg::*;;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 12;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [SAMPLE_W-1:0]  cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [SAMPLE_W-1:0]  sample_i    = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [SAMPLE_W-1:0]  mean_level_o;
  logic                 is_on_o;

  int                   mismatch_cnt;
  int                   pending_cnt;
  int unsigned          cycle_cnt     = 0;
  int unsigned          samples_sent  = 0;
  int unsigned          settings_used = 0;
  bit                   steady        = 1'b0;  // no idling on either side

  averaged_level_hysteresis_detector_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mean_level_o (mean_level_o),
    .is_on_o      (is_on_o)
  );

  alhd_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .mean_level_i   (mean_level_o),
    .is_on_i        (is_on_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  // 4-unit clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Result side stalls with a chance of 16 in 100, except in the steady phase
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 16);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending_cnt);
      $display("Verification failed");
      $finish;
    end
  end

  // One sample request, with a random gap before it; valid is left high
  task automatic send_sample(input sample_t s);
    while (!steady && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    samples_sent++;
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  // Both registers, back to back; only called while the block is idle
  task automatic apply_thresholds(input sample_t on_thr, input sample_t off_thr);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_TURN_ON;
    cfg_data_i <= on_thr;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_TURN_OFF;
    cfg_data_i <= off_thr;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    settings_used++;
  endtask

  // Plateaus at the thresholds, their midpoint or a random level with noise, plus rail and uniform samples
  task automatic run_random_phase(input sample_t on_thr, input sample_t off_thr,
                                  input int n_items);
    int level;
    int pick;
    int v;
    level = 0;
    drain_results();
    apply_thresholds(on_thr, off_thr);
    for (int i = 0; i < n_items; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(0, 3))
          0:       level = int'(on_thr);
          1:       level = int'(off_thr);
          2:       level = (int'(on_thr) + int'(off_thr)) / 2;
          default: level = int'($urandom_range(0, 4095));
        endcase
      end
      pick = int'($urandom_range(0, 99));
      if (pick < 70) begin
        v = level + int'($urandom_range(0, 400)) - 200;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end else if (pick < 85) begin
        v = pick[0] ? 4095 : 0;
      end else begin
        v = int'($urandom_range(0, 4095));
      end
      send_sample(sample_t'(v));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: window starts at zero, so the mean climbs from reset
    apply_thresholds(12'd300, 12'd255);
    send_sample(12'd0);      // lowest sample, state stays off
    send_sample(12'd4095);   // mean equals the off threshold: held
    send_sample(12'd705);    // mean equals the on threshold: held off
    send_sample(12'd16);     // mean just above on threshold: switch on
    repeat (14) send_sample(12'd0);  // full-scale sample leaves the window: off
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'd4095);
    // Crossed thresholds: mean above on and below off, on must win
    drain_results();
    apply_thresholds(12'd100, 12'd3000);
    send_sample(12'd4095);
    send_sample(12'd4095);

    // Random phases over several threshold settings
    steady = 1'b1;
    run_random_phase(TURN_ON_RST, TURN_OFF_RST, 70);
    steady = 1'b0;
    run_random_phase(12'd0, 12'd0, 60);
    run_random_phase(12'd4095, 12'd4095, 60);
    run_random_phase(12'd0, 12'd4095, 60);
    run_random_phase(12'd4095, 12'd0, 60);
    run_random_phase(12'd1000, 12'd3000, 60);
    repeat (3) begin
      run_random_phase(sample_t'($urandom_range(0, 4095)),
                       sample_t'($urandom_range(0, 4095)), 55);
    end

    // Let stray results show up after the last expected one
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d samples under %0d threshold settings (extremes and crossed pairs).",
             samples_sent, settings_used);
    $display("Mismatches counted: %0d", mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
